### rtl/core/pie_pkg.sv
// shared types, sizes and helpers for the palette index encoder
// no dependencies
package pie_pkg;

  localparam int PAL_DEPTH = 256;
  localparam int ID_W      = 16;
  localparam int IDX_W     = $clog2(PAL_DEPTH);
  localparam int CNT_W     = $clog2(PAL_DEPTH + 1);
  localparam int BITS_W    = 4;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic             last;
    logic             found;
    logic             added;
    logic [IDX_W-1:0] idx;
  } probe_t;

  // ceil(log2(count)), zero for a count of zero or one
  function automatic logic [BITS_W-1:0] index_bits(input logic [CNT_W-1:0] count);
    logic [CNT_W-1:0]  n;
    logic [BITS_W-1:0] b;
    n = count - CNT_W'(1);
    b = '0;
    for (int k = 0; k < CNT_W; k++) begin
      if (n[k]) begin
        b = BITS_W'(k + 1);
      end
    end
    if (count <= CNT_W'(1)) begin
      b = '0;
    end
    return b;
  endfunction

endpackage

### rtl/core/pie_cell.sv
// one palette slot: holds an entry, matches or claims it as a probe passes
// depends on pie_pkg
module pie_cell import pie_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] slot_idx,
  input  logic [CNT_W-1:0] cnt_i,
  input  probe_t           p_i,
  output probe_t           p_o
);

  logic [ID_W-1:0] entry_r;
  probe_t          p_r;
  probe_t          p_nxt;
  logic            used;
  logic            hit;
  logic            claim;

  assign used  = CNT_W'(slot_idx) < cnt_i;
  assign hit   = p_i.valid && !p_i.found && used && (entry_r == p_i.id);
  assign claim = p_i.valid && !p_i.found && (CNT_W'(slot_idx) == cnt_i);

  always_comb begin
    p_nxt = p_i;
    if (hit || claim) begin
      p_nxt.found = 1'b1;
      p_nxt.idx   = slot_idx;
    end
    if (claim) begin
      p_nxt.added = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r.valid <= 1'b0;
    end else begin
      p_r.valid <= p_nxt.valid;
    end
    p_r.id    <= p_nxt.id;
    p_r.last  <= p_nxt.last;
    p_r.found <= p_nxt.found;
    p_r.added <= p_nxt.added;
    p_r.idx   <= p_nxt.idx;
    if (claim) begin
      entry_r <= p_i.id;
    end
  end

  assign p_o = p_r;

endmodule

### rtl/core/palette_index_encoder.sv
// palette index encoder top level: cell chain, result capture, output register
// depends on pie_pkg and pie_cell
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  block_id, last_in_section (tlast)
//  out_     out  out_tvalid/out_tready palette_index, count, bits, flags, section_end
//
// an item's probe walks the chain of PAL_DEPTH cells, one cell per clock, and is
// folded into the result at the chain end
// reset empties the palette count and clears the overflow flag; entries are not cleared
// a stalled output keeps its result while the next item runs; a second finished
// result waits in a holding register and in_tready stays low until the first leaves

module palette_index_encoder import pie_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // block_id[15:0]
  input  logic        in_tlast,   // last_in_section
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // palette_index[7:0], palette_count[16:8],
                                  // bits_per_index[20:17], zero fill
  output logic [1:0]  out_tuser,  // new_entry[0], overflowed[1]
  output logic        out_tlast   // section_end
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_t;

  typedef struct packed {
    logic [7:0]        index;
    logic              new_entry;
    logic [8:0]        count;
    logic [BITS_W-1:0] bits;
    logic              ovf;
    logic              last;
  } result_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r;
  result_t          out_r;
  result_t          pend_r;
  result_t          res;
  probe_t           chain [PAL_DEPTH+1];
  probe_t           pe;
  logic             in_acc;
  logic             out_free;
  logic [CNT_W-1:0] cnt_after;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    chain[0].valid = in_acc;
    chain[0].id    = in_tdata;
    chain[0].last  = in_tlast;
    chain[0].found = 1'b0;
    chain[0].added = 1'b0;
    chain[0].idx   = '0;
  end

  for (genvar i = 0; i < PAL_DEPTH; i++) begin : g_cell
    pie_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .slot_idx (IDX_W'(i)),
      .cnt_i    (cnt_r),
      .p_i      (chain[i]),
      .p_o      (chain[i+1])
    );
  end

  assign pe        = chain[PAL_DEPTH];
  assign cnt_after = cnt_r + CNT_W'(pe.added);

  always_comb begin
    res.index     = pe.found ? 8'(pe.idx) : 8'd0;
    res.new_entry = pe.added;
    res.count     = 9'(cnt_after);
    res.bits      = index_bits(cnt_after);
    res.ovf       = ovf_r | !pe.found;
    res.last      = pe.last;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (pe.valid) begin
          cnt_nxt   = pe.last ? '0 : cnt_after;
          ovf_nxt   = res.ovf;
          state_nxt = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      if (state_r == ST_RUN && pe.valid && out_free) begin
        out_valid_r <= 1'b1;
      end else if (state_r == ST_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (state_r == ST_RUN && pe.valid) begin
      if (out_free) begin
        out_r <= res;
      end else begin
        pend_r <= res;
      end
    end else if (state_r == ST_HOLD && out_free) begin
      out_r <= pend_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.bits, out_r.count, out_r.index};
  assign out_tuser  = {out_r.ovf, out_r.new_entry};
  assign out_tlast  = out_r.last;

`ifndef SYNTHESIS
  a_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    pe.valid |-> state_r == ST_RUN)
    else $error("probe left the chain outside a run");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(PAL_DEPTH))
    else $error("palette count beyond depth");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HOLD |-> out_valid_r)
    else $error("pending result with empty output register");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && pe.valid && pe.added) |-> pe.found)
    else $error("appended item without a slot");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(ovf_r) && $past(rst_n) |-> ovf_r)
    else $error("overflow flag dropped");
`endif

endmodule
